// ===== src/prac_pkg.sv =====
//------------------------------------------------------------------------------
// prac_pkg
// shared constants, types and functions for the point rotation core
//------------------------------------------------------------------------------
`default_nettype none
package prac_pkg;
    localparam int CordicStepsDefault = 24;
    localparam int GuardBits = 8;
    localparam int CW = 32;
    localparam int WW = 44;
    localparam int AW = 34;
    localparam int TolW = 31;
    localparam logic signed [AW-1:0] AngPi = 34'sd843314857;
    localparam logic signed [AW-1:0] AngHalfPi = 34'sd421657428;
    localparam logic signed [AW-1:0] AngTwoPi = 34'sd1686629713;
    localparam logic [31:0] InvGain = 32'd2608131496;

    function automatic logic signed [AW-1:0] atan_val(input int i);
        logic signed [AW-1:0] r;
        unique case (i)
            0: r = 34'sd210828714;
            1: r = 34'sd124459457;
            2: r = 34'sd65760959;
            3: r = 34'sd33381290;
            4: r = 34'sd16755422;
            5: r = 34'sd8385879;
            6: r = 34'sd4193963;
            7: r = 34'sd2097109;
            8: r = 34'sd1048571;
            9: r = 34'sd524287;
            default: r = (i < 29) ? (34'sd1 <<< (28 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] rot;
    } side_t;

    typedef struct packed {
        logic signed [WW-1:0] x;
        logic signed [WW-1:0] y;
        logic signed [AW-1:0] z;
    } cstate_t;
endpackage
`default_nettype wire

// ===== src/prac_if.sv =====
//------------------------------------------------------------------------------
// prac_in_if / prac_out_if
// request and result channels for the point rotation core
//------------------------------------------------------------------------------
`default_nettype none
interface prac_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] angle;
    modport source (output valid, point_x, point_y, center_x, center_y, angle, input ready);
    modport sink (input valid, point_x, point_y, center_x, center_y, angle, output ready);
endinterface

interface prac_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    modport source (output valid, rotated_x, rotated_y, input ready);
    modport sink (input valid, rotated_x, rotated_y, output ready);
endinterface
`default_nettype wire

// ===== src/prac_stage.sv =====
//------------------------------------------------------------------------------
// prac_stage
// one registered cordic micro-rotation, vectoring or rotation mode
//------------------------------------------------------------------------------
`default_nettype none
module prac_stage #(
    parameter int STEP = 0,
    parameter bit VECTORING = 1'b1,
    parameter int SW = 96
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vin,
    input  wire prac_pkg::cstate_t    din,
    input  wire logic [SW-1:0]        sin,
    output logic                      vout,
    output prac_pkg::cstate_t         dout,
    output logic [SW-1:0]             sout
);
    prac_pkg::cstate_t d_next;
    logic dir;
    logic signed [prac_pkg::WW-1:0] xs, ys;

    always_comb
    begin
        xs = din.x >>> STEP;
        ys = din.y >>> STEP;
        dir = VECTORING ? (din.y >= 0) : (din.z >= 0);
        if (dir == VECTORING)
        begin
            d_next.x = din.x + ys;
            d_next.y = din.y - xs;
        end
        else
        begin
            d_next.x = din.x - ys;
            d_next.y = din.y + xs;
        end
        if (dir)
            d_next.z = VECTORING ? din.z + prac_pkg::atan_val(STEP)
                                 : din.z - prac_pkg::atan_val(STEP);
        else
            d_next.z = VECTORING ? din.z - prac_pkg::atan_val(STEP)
                                 : din.z + prac_pkg::atan_val(STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= d_next;
            sout <= sin;
        end
    end
endmodule
`default_nettype wire

// ===== src/prac_gain.sv =====
//------------------------------------------------------------------------------
// prac_gain
// two-stage multiply by the inverse cordic gain, rounded half up
//------------------------------------------------------------------------------
`default_nettype none
module prac_gain #(
    parameter int SW = 96
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vin,
    input  wire logic [43:0]          din,
    input  wire logic [SW-1:0]        sin,
    output logic                      vout,
    output logic [43:0]               dout,
    output logic [SW-1:0]             sout
);
    logic [59:0] a_reg;
    logic [47:0] b_reg;
    logic        v1_reg;
    logic [SW-1:0] s1_reg;
    logic [47:0] b_full;
    logic [60:0] sum;

    assign b_full = 48'(din[15:0]) * 48'(prac_pkg::InvGain) + 48'h80000000;
    assign sum = 61'(a_reg) + 61'(b_reg >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vout <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            vout <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= 60'(din[43:16]) * 60'(prac_pkg::InvGain);
            b_reg <= b_full;
            s1_reg <= sin;
            dout <= 44'(sum >> 16);
            sout <= s1_reg;
        end
    end
endmodule
`default_nettype wire

// ===== src/point_rotate_about_center_core.sv =====
//------------------------------------------------------------------------------
// point_rotate_about_center_core
// rotates a point about a center with vectoring and rotation cordic pipelines
//------------------------------------------------------------------------------
// a request passes the front register, the vectoring stages, the first gain multiply, the tolerance register, the
// second gain multiply, the fold register, the rotation stages and the output register; throughput: one request per
// cycle while the output is not stalled, set by the fully unrolled cordic stages; a stall on the output freezes every
// stage, so nothing is lost or repeated; reset clears all valid bits and sets tol_reg to one
`default_nettype none
module point_rotate_about_center_core #(
    parameter int CORDIC_STEPS = prac_pkg::CordicStepsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    prac_in_if.sink          in_ch,
    prac_out_if.source       out_ch
);
    localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int SW = $bits(prac_pkg::side_t);
    localparam int WW = prac_pkg::WW;
    localparam int AW = prac_pkg::AW;

    logic [30:0] tol_reg;
    logic en;

    // front: offset and half-plane fold
    logic v0_reg;
    prac_pkg::cstate_t d0_reg;
    prac_pkg::side_t s0_reg;
    prac_pkg::cstate_t d0_next;
    prac_pkg::side_t s0_next;

    logic out_v_reg;
    logic signed [31:0] ox_reg, oy_reg;

    assign en = !out_v_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_comb
    begin
        logic signed [WW-1:0] dx, dy;
        dx = (WW'(in_ch.point_x) - WW'(in_ch.center_x)) <<< prac_pkg::GuardBits;
        dy = (WW'(in_ch.point_y) - WW'(in_ch.center_y)) <<< prac_pkg::GuardBits;
        d0_next.x = dx;
        d0_next.y = dy;
        d0_next.z = '0;
        if (dx < 0)
        begin
            if (dy >= 0)
            begin
                d0_next.x = dy; d0_next.y = -dx; d0_next.z = prac_pkg::AngHalfPi;
            end
            else
            begin
                d0_next.x = -dy; d0_next.y = dx; d0_next.z = -prac_pkg::AngHalfPi;
            end
        end
        s0_next.cx = in_ch.center_x;
        s0_next.cy = in_ch.center_y;
        s0_next.rot = in_ch.angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 31'd1;
            v0_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (en)
                v0_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg <= d0_next;
            s0_reg <= s0_next;
        end
    end

    // vectoring chain
    logic              vv [N+1];
    prac_pkg::cstate_t vd [N+1];
    logic [SW-1:0]     vs [N+1];
    assign vv[0] = v0_reg;
    assign vd[0] = d0_reg;
    assign vs[0] = s0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        prac_stage #(.STEP(i), .VECTORING(1'b1), .SW(SW)) u_st (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(vv[i]), .din(vd[i]), .sin(vs[i]),
            .vout(vv[i+1]), .dout(vd[i+1]), .sout(vs[i+1])
        );
    end

    // radius gain removal, z rides in the sideband
    localparam int SW2 = SW + AW;
    logic [43:0] g1_in;
    logic        g1_v;
    logic [43:0] rad;
    logic [SW2-1:0] g1_s;
    assign g1_in = (vd[N].x < 0) ? '0 : vd[N].x;

    prac_gain #(.SW(SW2)) u_g1 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(vv[N]), .din(g1_in),
        .sin({vs[N], vd[N].z}), .vout(g1_v), .dout(rad), .sout(g1_s)
    );

    // tolerance test and angle sum
    logic v1_reg;
    logic keep1_reg;
    logic [43:0] rad1_reg;
    logic signed [AW-1:0] z1_reg;
    prac_pkg::side_t s1_reg;
    prac_pkg::side_t g1_side;
    logic signed [AW-1:0] g1_z;
    assign g1_side = g1_s[SW2-1:AW];
    assign g1_z = g1_s[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= g1_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            keep1_reg <= rad >= (44'(tol_reg) << prac_pkg::GuardBits);
            rad1_reg <= rad;
            z1_reg <= g1_z + AW'(g1_side.rot);
            s1_reg <= g1_side;
        end
    end

    // angle reduction, up to two turns, second gain removal
    logic signed [AW-1:0] zr;
    always_comb
    begin
        zr = z1_reg;
        if (zr >= prac_pkg::AngPi)
            zr = zr - prac_pkg::AngTwoPi;
        else if (zr < -prac_pkg::AngPi)
            zr = zr + prac_pkg::AngTwoPi;
        if (zr >= prac_pkg::AngPi)
            zr = zr - prac_pkg::AngTwoPi;
        else if (zr < -prac_pkg::AngPi)
            zr = zr + prac_pkg::AngTwoPi;
    end

    localparam int SW3 = SW + AW + 1;
    logic g2_v;
    logic [43:0] mag;
    logic [SW3-1:0] g2_s;
    prac_gain #(.SW(SW3)) u_g2 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v1_reg), .din(rad1_reg),
        .sin({s1_reg, zr, keep1_reg}), .vout(g2_v), .dout(mag), .sout(g2_s)
    );

    // quadrant fold into rotation start
    localparam int SW4 = SW + 1;
    logic              rv [N+1];
    prac_pkg::cstate_t rd [N+1];
    logic [SW4-1:0]    rs [N+1];
    logic signed [AW-1:0] g2_z;
    prac_pkg::cstate_t r0_next;
    assign g2_z = g2_s[AW:1];

    always_comb
    begin
        r0_next.x = mag;
        r0_next.y = '0;
        r0_next.z = g2_z;
        if (g2_z > prac_pkg::AngHalfPi)
        begin
            r0_next.x = '0; r0_next.y = mag; r0_next.z = g2_z - prac_pkg::AngHalfPi;
        end
        else if (g2_z < -prac_pkg::AngHalfPi)
        begin
            r0_next.x = '0; r0_next.y = -mag; r0_next.z = g2_z + prac_pkg::AngHalfPi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv[0] <= 1'b0;
        else if (en)
            rv[0] <= g2_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd[0] <= r0_next;
            rs[0] <= {g2_s[SW3-1:AW+1], g2_s[0]};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        prac_stage #(.STEP(i), .VECTORING(1'b0), .SW(SW4)) u_st (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(rv[i]), .din(rd[i]), .sin(rs[i]),
            .vout(rv[i+1]), .dout(rd[i+1]), .sout(rs[i+1])
        );
    end

    // round, add center, saturate
    prac_pkg::side_t fs;
    logic fkeep;
    logic signed [WW-1:0] rx, ry;
    logic signed [WW:0] sx, sy;
    assign fs = rs[N][SW4-1:1];
    assign fkeep = rs[N][0];
    assign rx = fkeep ? ((rd[N].x + WW'(128)) >>> prac_pkg::GuardBits) : WW'(0);
    assign ry = fkeep ? ((rd[N].y + WW'(128)) >>> prac_pkg::GuardBits) : WW'(0);
    assign sx = (WW+1)'(fs.cx) + (WW+1)'(rx);
    assign sy = (WW+1)'(fs.cy) + (WW+1)'(ry);

    function automatic logic signed [31:0] sat(input logic signed [WW:0] v);
        if (v > (WW+1)'(64'sd2147483647))
            return 32'sh7fffffff;
        else if (v < -(WW+1)'(64'sd2147483648))
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= rv[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= sat(sx);
            oy_reg <= sat(sy);
        end
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.rotated_x = ox_reg;
    assign out_ch.rotated_y = oy_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_ch.ready |=> out_v_reg && $stable(ox_reg) && $stable(oy_reg))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_v_reg || out_ch.ready))
        else $error("ready does not follow output state");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v0_reg) && $stable(v1_reg))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// checks the point rotation core: random and corner requests with idle and
// stall bursts, results compared field by field against a fixed-point
// cordic predictor, several tolerance settings written between phases
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    localparam int Steps = 24;
    localparam int Latency = 2 * Steps + 8;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] ang;
    } point_req_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } rotated_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;

    prac_in_if in_ch ();
    prac_out_if out_ch ();

    point_rotate_about_center_core #(.CORDIC_STEPS(Steps)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    point_req_t pending_q[$];
    rotated_t expected_q[$];
    logic [30:0] tolerance = 31'd1;
    int mismatches = 0;
    bit failed = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    bit in_fire = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint scale_inv_gain(longint v);
        longint unsigned u, hi, lo, a, b;
        u = v;
        hi = u >> 16;
        lo = u & 64'hFFFF;
        a = hi * 64'd2608131496;
        b = (lo * 64'd2608131496 + 64'h80000000) >> 16;
        return longint'((a + b) >> 16);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint t[29] = '{210828714, 124459457, 65760959, 33381290, 16755422,
            8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
            8, 4, 2, 1};
        return (i < 29) ? t[i] : 0;
    endfunction

    function automatic rotated_t rotate_about_center(point_req_t r, logic [30:0] tol);
        longint x, y, z, nx, ny, t, radius, ox, oy, cx, cy;
        rotated_t res;
        cx = r.cx;
        cy = r.cy;
        x = (longint'(r.px) - cx) * 256;
        y = (longint'(r.py) - cy) * 256;
        z = 0;
        ox = 0;
        oy = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 421657428;
            end
            else
            begin
                x = -y; y = t; z = -421657428;
            end
        end
        for (int i = 0; i < Steps; i++)
        begin
            if (y >= 0)
            begin
                nx = x + shr(y, i); ny = y - shr(x, i); z += arctan_step(i);
            end
            else
            begin
                nx = x - shr(y, i); ny = y + shr(x, i); z -= arctan_step(i);
            end
            x = nx; y = ny;
        end
        radius = scale_inv_gain(x < 0 ? 0 : x);
        if (radius >= (longint'(tol) << 8))
        begin
            z += longint'(r.ang);
            while (z >= 843314857)
                z -= 1686629713;
            while (z < -843314857)
                z += 1686629713;
            x = scale_inv_gain(radius);
            y = 0;
            if (z > 421657428)
            begin
                y = x; x = 0; z -= 421657428;
            end
            else if (z < -421657428)
            begin
                y = -x; x = 0; z += 421657428;
            end
            for (int i = 0; i < Steps; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - shr(y, i); ny = y + shr(x, i); z -= arctan_step(i);
                end
                else
                begin
                    nx = x + shr(y, i); ny = y - shr(x, i); z += arctan_step(i);
                end
                x = nx; y = ny;
            end
            ox = shr(x + 128, 8);
            oy = shr(y + 128, 8);
        end
        res.rx = 32'(clamp32(cx + ox));
        res.ry = 32'(clamp32(cy + oy));
        return res;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000) << 6;
        endcase
    endfunction

    function automatic point_req_t rand_req();
        point_req_t r;
        r.cx = rand_coord();
        r.cy = rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            r.px = rand_coord();
            r.py = rand_coord();
        end
        else
        begin
            r.px = r.cx + (32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) << 4);
            r.py = r.cy + (32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) << 4);
        end
        r.ang = $urandom;
        return r;
    endfunction

    function automatic point_req_t make_req(int px, int py, int cx, int cy, int ang);
        point_req_t r;
        r.px = px; r.py = py; r.cx = cx; r.cy = cy; r.ang = ang;
        return r;
    endfunction

    // input monitor: requests taken at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(rotate_about_center(
                    {in_ch.point_x, in_ch.point_y, in_ch.center_x,
                     in_ch.center_y, in_ch.angle}, tolerance));
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (!in_ch.valid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0 && !cfg_we)
                begin
                    point_req_t r;
                    r = pending_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.point_x <= r.px;
                    in_ch.point_y <= r.py;
                    in_ch.center_x <= r.cx;
                    in_ch.center_y <= r.cy;
                    in_ch.angle <= r.ang;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 11);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (hold_req && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt >= 300)
                    hold_done <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 11);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            rotated_t e;
            if (expected_q.size() == 0)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", out_ch.rotated_x,
                        out_ch.rotated_y);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.rx !== out_ch.rotated_x || e.ry !== out_ch.rotated_y)
                begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d got x=%0d y=%0d", e.rx,
                            e.ry, out_ch.rotated_x, out_ch.rotated_y);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [30:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        tolerance = v;
    endtask

    initial
    begin
        logic [30:0] tols[5] = '{31'd0, 31'h7FFFFFFF, 31'd100000, 31'd1, 31'd3};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners at reset tolerance
        pending_q.push_back(make_req(0, 0, 0, 0, 0));
        pending_q.push_back(make_req(65536, 0, 0, 0, 421657428));
        pending_q.push_back(make_req(-65536, 0, 0, 0, 843314857));
        pending_q.push_back(make_req(0, -65536, 0, 0, -843314857));
        pending_q.push_back(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
            32'h80000000, 32'h7FFFFFFF));
        pending_q.push_back(make_req(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h80000000));
        pending_q.push_back(make_req(32'h7FFFFFFF, 0, 32'h7FFFFFF0, 0, 421657428));
        pending_q.push_back(make_req(32'h80000000, 0, 32'h80000010, 0, 843314857));
        pending_q.push_back(make_req(1, 0, 0, 0, 100));
        pending_q.push_back(make_req(0, 1, 5, 5, -100));
        pending_q.push_back(make_req(-1, -1, 0, 0, 32'hFFFFFFFF));
        pending_q.push_back(make_req(600000, -700000, 123, -456, 800000000));
        pending_q.push_back(make_req(-600000, 700000, 0, 0, -800000000));
        pending_q.push_back(make_req(-600000, -700000, 0, 0, 32'h40000000));
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_tolerance(tols[ph]);
            if (ph == 0)
                pending_q.push_back(make_req(0, 0, 7, 7, 12345));
            if (ph == 2)
            begin
                pending_q.push_back(make_req(3000, 0, 0, 0, 500));
                pending_q.push_back(make_req(32'h0FFFFFFF, 0, 0, 0, 500));
            end
            for (int k = 0; k < 360; k++)
                pending_q.push_back(rand_req());
            if (ph == 3)
                hold_req = 1;
            if (ph == 4)
            begin
                while (pending_q.size() > 180)
                    @(posedge clk);
                calm = 1;
            end
            wait_drained();
        end

        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/prac_pkg.sv
src/prac_if.sv
src/prac_stage.sv
src/prac_gain.sv
src/point_rotate_about_center_core.sv
tb/tb_top.sv
